// ----- sv/ssfs_pkg.sv -----
package ssfs_pkg;

  // Default widths of the frame counter and of the clip coordinates
  localparam int FRAME_BITS_DEF = 12;
  localparam int COORD_BITS_DEF = 12;

  // Stream and configuration port widths
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 72;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Field widths
  localparam int ACC_BITS     = 17;
  localparam int PERIOD_BITS  = 16;
  localparam int SHEET_BITS   = 12;
  localparam int GRID_BITS    = 7;
  localparam int COUNT_BITS   = 13;
  localparam int ELAPSED_BITS = 16;
  localparam int TARGET_BITS  = 12;

  // Item kinds carried on tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_JUMP = 1'b1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SHEET_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHEET_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLUMNS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_COUNT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_UPDATE_PERIOD = 3'd5;

endpackage

// ----- sv/ssfs_div.sv -----
module ssfs_div #(
  parameter int NW = 17,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW:0]   shifted;
  logic [DW+1:0] diff;
  logic          fits;

  // One quotient bit per cycle, restoring form
  assign shifted = {rem_r, quo_r[NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = ~diff[DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DW-1:0] : shifted[DW-1:0];
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- sv/ssfs_mul.sv -----
module ssfs_mul #(
  parameter int AW = 12,
  parameter int BW = 7,
  parameter int PW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [AW-1:0] mcand,
  input  logic [BW-1:0] mplier,
  output logic          done,
  output logic [PW-1:0] product
);

  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] a_r;
  logic [BW-1:0] b_r;
  logic [PW-1:0] p_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(BW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Shift-add, one multiplier bit per cycle; product wraps at PW bits
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= PW'(mcand);
      b_r <= mplier;
      p_r <= '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        p_r <= p_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign done    = done_r;
  assign product = p_r;

endmodule

// ----- sv/sprite_sheet_frame_sequencer_unit.sv -----
// A tick with a nonzero period runs the time division, the frame wrap, the column split and
// the offset multipliers in turn; a jump or a paused tick skips the frame wrap. The cell
// width and height divisions run alongside the time division. One item at a time; the next
// transfer is taken the cycle after the result is loaded. Dividers and multipliers are bit-serial.
// Reset: synchronous, active low; frame and accumulator clear, registers take their defaults.
module sprite_sheet_frame_sequencer_unit #(
  parameter int FRAME_BITS = ssfs_pkg::FRAME_BITS_DEF,
  parameter int COORD_BITS = ssfs_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: elapsed_time[15:0], target_frame[27:16], zero pad [31:28]
  input  logic [ssfs_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: cmd (0 = tick, 1 = jump)
  input  logic                              in_tuser,
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: frame_index[11:0], clip_x[23:12], clip_y[47:24], clip_width[59:48],
  //        clip_height[71:60]
  output logic [ssfs_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ssfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import ssfs_pkg::*;

  localparam int CNT_W  = FRAME_BITS + 1;
  localparam int FSUM_W = ((FRAME_BITS > ACC_BITS) ? FRAME_BITS : ACC_BITS) + 1;
  localparam int CMP_W  = 18;
  localparam logic [CMP_W-1:0] CNT_LIM = CMP_W'(2 ** FRAME_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_DIV3 = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;

  // Configuration registers
  logic [SHEET_BITS-1:0]  sheet_w_r;
  logic [SHEET_BITS-1:0]  sheet_h_r;
  logic [GRID_BITS-1:0]   rows_r;
  logic [GRID_BITS-1:0]   cols_r;
  logic [COUNT_BITS-1:0]  count_cfg_r;
  logic [PERIOD_BITS-1:0] period_r;

  // Animation state
  logic [FRAME_BITS-1:0]  cur_r;
  logic [ACC_BITS-1:0]    acc_r;
  logic                   cmd_r;
  logic [2:0]             state_r;
  logic [2:0]             state_nxt;

  // Output register
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic [OUT_DATA_W-1:0]  out_data_nxt;

  logic                   in_accept;
  logic                   cfg_hit;
  logic [ELAPSED_BITS-1:0] in_elapsed;
  logic [TARGET_BITS-1:0]  in_target;
  logic [ACC_BITS-1:0]    acc_sum;

  logic [GRID_BITS-1:0]   rows_eff;
  logic [GRID_BITS-1:0]   cols_eff;
  logic [13:0]            grid_cells;
  logic [CMP_W-1:0]       count_raw;
  logic [CMP_W-1:0]       count_sat;
  logic [CNT_W-1:0]       frame_count;

  // Unit handshakes and results
  logic                   done_t, done_w, done_h, done_f, done_c, done_x, done_y;
  logic [ACC_BITS-1:0]    quo_t;
  logic [PERIOD_BITS-1:0] rem_t;
  logic [SHEET_BITS-1:0]  quo_w;
  logic [SHEET_BITS-1:0]  quo_h;
  logic [CNT_W-1:0]       rem_f;
  logic [FRAME_BITS-1:0]  quo_c;
  logic [GRID_BITS-1:0]   rem_c;
  logic [COORD_BITS-1:0]  prod_x;
  logic [2*COORD_BITS-1:0] prod_y;

  logic                   div1_done;
  logic                   start_f;
  logic                   start_c;
  logic                   start_m;
  logic                   out_load;
  logic [FSUM_W-1:0]      f_sum;
  logic [FRAME_BITS-1:0]  split_src;

  assign in_accept  = in_tvalid & in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign in_elapsed = in_tdata[ELAPSED_BITS-1:0];
  assign in_target  = in_tdata[ELAPSED_BITS +: TARGET_BITS];
  assign acc_sum    = acc_r + {1'b0, in_elapsed};

  assign cfg_ready  = 1'b1;
  assign cfg_hit    = cfg_valid & (cfg_index inside {[REG_SHEET_WIDTH:REG_UPDATE_PERIOD]});

  // Zero rows or columns count as one
  assign rows_eff   = (rows_r == '0) ? GRID_BITS'(1) : rows_r;
  assign cols_eff   = (cols_r == '0) ? GRID_BITS'(1) : cols_r;
  assign grid_cells = rows_eff * cols_eff;

  // Frames in use: given count, or the whole grid; saturate at 2^FRAME_BITS
  assign count_raw   = (count_cfg_r == '0) ? CMP_W'(grid_cells) : CMP_W'(count_cfg_r);
  assign count_sat   = (count_raw > CNT_LIM) ? CNT_LIM : count_raw;
  assign frame_count = count_sat[CNT_W-1:0];

  // Sequencing of the serial units
  assign div1_done = done_t & done_w & done_h;
  assign start_f   = (state_r == S_DIV1) && div1_done && (cmd_r == CMD_TICK) &&
                     (period_r != '0);
  assign start_c   = ((state_r == S_DIV1) && div1_done && !start_f) ||
                     ((state_r == S_DIV2) && done_f);
  assign start_m   = (state_r == S_DIV3) && done_c;
  assign out_load  = (state_r == S_MUL) && done_x && done_y &&
                     (!out_valid_r || out_tready);

  assign f_sum     = FSUM_W'(cur_r) + FSUM_W'(quo_t);
  // Column split reads the freshly wrapped frame straight from the wrap unit
  assign split_src = (state_r == S_DIV2) ? rem_f[FRAME_BITS-1:0] : cur_r;

  // Time accumulator / period: quotient advances the frame, remainder is kept
  ssfs_div #(.NW(ACC_BITS), .DW(PERIOD_BITS)) u_div_time (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_accept),
    .dividend  (acc_sum),
    .divisor   (period_r),
    .done      (done_t),
    .quotient  (quo_t),
    .remainder (rem_t)
  );

  // Cell width and height, run alongside the time division
  ssfs_div #(.NW(SHEET_BITS), .DW(GRID_BITS)) u_div_cw (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_accept),
    .dividend  (sheet_w_r),
    .divisor   (cols_eff),
    .done      (done_w),
    .quotient  (quo_w),
    .remainder ()
  );

  ssfs_div #(.NW(SHEET_BITS), .DW(GRID_BITS)) u_div_ch (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_accept),
    .dividend  (sheet_h_r),
    .divisor   (rows_eff),
    .done      (done_h),
    .quotient  (quo_h),
    .remainder ()
  );

  // Wrap the advanced frame modulo the frame count
  ssfs_div #(.NW(FSUM_W), .DW(CNT_W)) u_div_wrap (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_f),
    .dividend  (f_sum),
    .divisor   (frame_count),
    .done      (done_f),
    .quotient  (),
    .remainder (rem_f)
  );

  // Split the frame into grid row and column
  ssfs_div #(.NW(FRAME_BITS), .DW(GRID_BITS)) u_div_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_c),
    .dividend  (split_src),
    .divisor   (cols_eff),
    .done      (done_c),
    .quotient  (quo_c),
    .remainder (rem_c)
  );

  // Pixel offsets of the clip
  ssfs_mul #(.AW(SHEET_BITS), .BW(GRID_BITS), .PW(COORD_BITS)) u_mul_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_m),
    .mcand   (quo_w),
    .mplier  (rem_c),
    .done    (done_x),
    .product (prod_x)
  );

  ssfs_mul #(.AW(SHEET_BITS), .BW(FRAME_BITS), .PW(2*COORD_BITS)) u_mul_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_m),
    .mcand   (quo_h),
    .mplier  (quo_c),
    .done    (done_y),
    .product (prod_y)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_accept) state_nxt = S_DIV1;
      S_DIV1: begin
        if (start_f) begin
          state_nxt = S_DIV2;
        end else if (start_c) begin
          state_nxt = S_DIV3;
        end
      end
      S_DIV2: if (start_c) state_nxt = S_DIV3;
      S_DIV3: if (start_m) state_nxt = S_MUL;
      S_MUL:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers; a write to a listed register also rewinds the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sheet_w_r   <= SHEET_BITS'(1);
      sheet_h_r   <= SHEET_BITS'(1);
      rows_r      <= GRID_BITS'(1);
      cols_r      <= GRID_BITS'(1);
      count_cfg_r <= '0;
      period_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SHEET_WIDTH:   sheet_w_r   <= cfg_data[SHEET_BITS-1:0];
        REG_SHEET_HEIGHT:  sheet_h_r   <= cfg_data[SHEET_BITS-1:0];
        REG_GRID_ROWS:     rows_r      <= cfg_data[GRID_BITS-1:0];
        REG_GRID_COLUMNS:  cols_r      <= cfg_data[GRID_BITS-1:0];
        REG_SPRITE_COUNT:  count_cfg_r <= cfg_data[COUNT_BITS-1:0];
        REG_UPDATE_PERIOD: period_r    <= cfg_data[PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Frame and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      acc_r <= '0;
      cmd_r <= CMD_TICK;
    end else begin
      if (in_accept) begin
        cmd_r <= in_tuser;
        // Jump: take the target as given, no wrap until the next tick
        if (in_tuser == CMD_JUMP) begin
          cur_r <= FRAME_BITS'(in_target);
        end
      end
      if (state_r == S_DIV1 && div1_done && cmd_r == CMD_TICK) begin
        // Paused animation drops the accumulated time
        acc_r <= (period_r == '0) ? '0 : ACC_BITS'(rem_t);
      end
      if (state_r == S_DIV2 && done_f) begin
        cur_r <= rem_f[FRAME_BITS-1:0];
      end
      if (cfg_hit) begin
        cur_r <= '0;
      end
    end
  end

  // Result word
  assign out_data_nxt = {
    12'(COORD_BITS'(quo_h)),
    12'(COORD_BITS'(quo_w)),
    24'(prod_y),
    12'(prod_x),
    12'(cur_r)
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The kept remainder is always below the period
  a_acc_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    start_f |=> (acc_r < {1'b0, period_r}))
    else $error("accumulator not below period after a tick");

  // A paused tick clears the accumulator
  a_pause_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV1 && div1_done && cmd_r == CMD_TICK && period_r == '0)
      |=> (acc_r == '0))
    else $error("paused tick left time in the accumulator");

  // A wrapped frame lies inside the frame count
  a_frame_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV2 && done_f) |=> (CNT_W'(cur_r) < frame_count))
    else $error("frame not wrapped into the frame count");

  // A result is loaded only when the output register is free or drains
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !out_load)
    else $error("pending result overwritten");

endmodule

// ----- tb/sv/tb_sprite_sheet_frame_sequencer_unit.sv -----
module tb_sprite_sheet_frame_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ssfs_pkg::*;

  // Frame count in use saturates at 2^FRAME_BITS
  localparam int FRAMES_MAX  = 1 << FRAME_BITS_DEF;
  localparam int ITEM_BUDGET = 1500;
  // Cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT = 4000;
  // Long receiver hold-off, long enough to back the block up into its input
  localparam int LONG_HOLD   = 400;
  // Wait well past the slowest item's time from transfer to result
  localparam int TAIL_CYCLES = 100;
  localparam int IN_PAD_W    = IN_DATA_W - ELAPSED_BITS - TARGET_BITS;

  // Indexes past the register list; writes there must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                    cmd;
    logic [ELAPSED_BITS-1:0] elapsed;
    logic [TARGET_BITS-1:0]  target;
  } anim_cmd_t;

  // Packed from the top down so that frame_index lands in the lowest bits of out_tdata
  typedef struct packed {
    logic [11:0] clip_height;
    logic [11:0] clip_width;
    logic [23:0] clip_y;
    logic [11:0] clip_x;
    logic [11:0] frame_index;
  } clip_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // tdata: elapsed_time[15:0], target_frame[27:16], zero pad [31:28]
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  // tuser: cmd (0 = tick, 1 = jump)
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // tdata: frame_index, clip_x, clip_y, clip_width, clip_height (lowest first)
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  sprite_sheet_frame_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sequencer mirror: registers and state as they stand after reset
  // ---------------------------------------------------------------------------
  logic [SHEET_BITS-1:0]     sheet_w = SHEET_BITS'(1);
  logic [SHEET_BITS-1:0]     sheet_h = SHEET_BITS'(1);
  logic [GRID_BITS-1:0]      rows_reg = GRID_BITS'(1);
  logic [GRID_BITS-1:0]      cols_reg = GRID_BITS'(1);
  logic [COUNT_BITS-1:0]     count_reg = '0;
  logic [PERIOD_BITS-1:0]    period_reg = '0;
  logic [FRAME_BITS_DEF-1:0] cur_frame = '0;
  logic [ACC_BITS-1:0]       time_acc = '0;

  anim_cmd_t cmd_queue[$];    // items waiting to be offered
  clip_t     clip_queue[$];   // results owed by the block, oldest first
  anim_cmd_t in_item;
  clip_t     want, got;
  int        in_gap, out_gap, hold_left, stall_cycles, mismatches, items_pushed;
  bit        in_idle, out_idle, hold_request;

  // Any register write restarts the animation at frame 0; the accumulator survives.
  // Indexes past the list are ignored outright.
  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_SHEET_WIDTH:   sheet_w = val[SHEET_BITS-1:0];
      REG_SHEET_HEIGHT:  sheet_h = val[SHEET_BITS-1:0];
      REG_GRID_ROWS:     rows_reg = val[GRID_BITS-1:0];
      REG_GRID_COLUMNS:  cols_reg = val[GRID_BITS-1:0];
      REG_SPRITE_COUNT:  count_reg = val[COUNT_BITS-1:0];
      REG_UPDATE_PERIOD: period_reg = val[PERIOD_BITS-1:0];
      default:           return;
    endcase
    cur_frame = '0;
  endfunction

  // Zero rows or columns count as one; a zero sprite count means the whole grid
  function automatic int unsigned frames_in_use();
    int unsigned rows_e, cols_e, n;
    rows_e = (rows_reg == 0) ? 1 : rows_reg;
    cols_e = (cols_reg == 0) ? 1 : cols_reg;
    n = (count_reg == 0) ? rows_e * cols_e : count_reg;
    return (n > FRAMES_MAX) ? FRAMES_MAX : n;
  endfunction

  // Advance the frame for one item and return its clip rectangle
  function automatic clip_t next_frame_clip(anim_cmd_t c);
    clip_t       r;
    int unsigned rows_e, cols_e, acc_sum, cw, ch;
    rows_e = (rows_reg == 0) ? 1 : rows_reg;
    cols_e = (cols_reg == 0) ? 1 : cols_reg;
    if (c.cmd == CMD_JUMP) begin
      cur_frame = c.target;
    end else if (period_reg == 0) begin
      // paused: frame holds, accumulator drops
      time_acc = '0;
    end else begin
      acc_sum   = (time_acc + c.elapsed) & ((1 << ACC_BITS) - 1);
      cur_frame = FRAME_BITS_DEF'((cur_frame + acc_sum / period_reg) % frames_in_use());
      time_acc  = ACC_BITS'(acc_sum % period_reg);
    end
    cw = sheet_w / cols_e;
    ch = sheet_h / rows_e;
    // assignments truncate to the coordinate widths
    r.frame_index = cur_frame;
    r.clip_x      = 12'((cur_frame % cols_e) * cw);
    r.clip_y      = 24'((cur_frame / cols_e) * ch);
    r.clip_width  = 12'(cw);
    r.clip_height = 12'(ch);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued items, predict on every input transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        clip_queue.push_back(next_frame_clip(in_item));
      end
      // Only touch the bus once the current item is gone
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_tvalid <= 1'b0;
          in_gap--;
        end else if (cmd_queue.size() != 0) begin
          in_item = cmd_queue.pop_front();
          in_tuser  <= in_item.cmd;
          in_tdata  <= {{IN_PAD_W{1'b0}}, in_item.target, in_item.elapsed};
          in_tvalid <= 1'b1;
          // gap to leave after this item is taken
          in_gap = in_idle ? $urandom_range(0, 7) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (clip_queue.size() == 0) begin
          $error("result with no item outstanding: %h", out_tdata);
          mismatches++;
        end else begin
          want = clip_queue.pop_front();
          got  = out_tdata;
          check_field("frame_index", want.frame_index, got.frame_index);
          check_field("clip_x", want.clip_x, got.clip_x);
          check_field("clip_y", want.clip_y, got.clip_y);
          check_field("clip_width", want.clip_width, got.clip_width);
          check_field("clip_height", want.clip_height, got.clip_height);
        end
        out_gap = out_idle ? $urandom_range(0, 7) : 0;
      end
      // Long hold-off: count it out here, independent of the stimulus thread
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer on any channel proves progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_tick(logic [ELAPSED_BITS-1:0] elapsed);
    anim_cmd_t c;
    c.cmd     = CMD_TICK;
    c.elapsed = elapsed;
    c.target  = TARGET_BITS'($urandom_range(0, 4095));   // ignored by a tick, but toggle it anyway
    cmd_queue.push_back(c);
    items_pushed++;
  endtask

  task automatic push_jump(logic [TARGET_BITS-1:0] target);
    anim_cmd_t c;
    c.cmd     = CMD_JUMP;
    c.elapsed = ELAPSED_BITS'($urandom_range(0, 65535));
    c.target  = target;
    cmd_queue.push_back(c);
    items_pushed++;
  endtask

  // Mostly ticks, half of them sized against the period so frames wrap often; some
  // jumps, half of them to any 12-bit target, which may land past the frame count
  task automatic push_random_item();
    int unsigned lim;
    if ($urandom_range(0, 99) < 20) begin
      if ($urandom_range(0, 1))
        push_jump(TARGET_BITS'($urandom_range(0, 4095)));
      else
        push_jump(TARGET_BITS'($urandom_range(0, frames_in_use() - 1)));
    end else begin
      lim = period_reg * 3;
      if (lim > 65535) lim = 65535;
      if (lim == 0) lim = 40;
      case ($urandom_range(0, 5))
        0:       push_tick('0);
        1:       push_tick('1);
        2:       push_tick(ELAPSED_BITS'($urandom_range(0, 65535)));
        default: push_tick(ELAPSED_BITS'($urandom_range(0, lim)));
      endcase
    end
  endtask

  // Hold a write on the config channel until it is taken, then mirror it
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // Legal extremes, small grids for frequent wraps, and raw 16-bit values now and then
  function automatic logic [CFG_DATA_W-1:0] random_reg_value(int idx);
    int unsigned v;
    case (idx)
      REG_SHEET_WIDTH, REG_SHEET_HEIGHT:
        case ($urandom_range(0, 4))
          0:       v = 1;
          1:       v = 4095;
          2:       v = $urandom_range(0, 65535);
          default: v = $urandom_range(1, 4095);
        endcase
      REG_GRID_ROWS, REG_GRID_COLUMNS:
        case ($urandom_range(0, 5))
          0:       v = 1;
          1:       v = 64;
          2:       v = 0;
          3:       v = $urandom_range(0, 65535);
          default: v = $urandom_range(1, 16);
        endcase
      REG_SPRITE_COUNT:
        case ($urandom_range(0, 4))
          0:       v = 0;
          1:       v = 4096;
          2:       v = $urandom_range(0, 65535);
          default: v = $urandom_range(1, 64);
        endcase
      default:
        case ($urandom_range(0, 5))
          0:       v = 0;
          1:       v = 1;
          2:       v = 65535;
          3:       v = $urandom_range(0, 65535);
          default: v = $urandom_range(1, 200);
        endcase
    endcase
    return CFG_DATA_W'(v);
  endfunction

  // Block is idle once nothing is queued, offered or owed
  task automatic wait_drained();
    do @(negedge clk); while (cmd_queue.size() != 0 || in_tvalid || clip_queue.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults: 1x1 grid, paused; jump past the count, then a paused tick
    in_idle  = 1'b0;
    out_idle = 1'b0;
    push_tick('0);
    push_tick('1);
    push_jump('1);
    push_tick(16'd5);
    push_jump('0);
    wait_drained();

    // Largest legal sheet, 64x64 grid, count from the grid, period 1
    write_reg(REG_SHEET_WIDTH, 16'd4095);
    write_reg(REG_SHEET_HEIGHT, 16'd4095);
    write_reg(REG_GRID_ROWS, 16'd64);
    write_reg(REG_GRID_COLUMNS, 16'd64);
    write_reg(REG_SPRITE_COUNT, 16'd0);
    write_reg(REG_UPDATE_PERIOD, 16'd1);
    @(negedge clk);
    push_tick('1);
    push_tick(16'd1);
    push_jump('1);
    push_tick('0);
    push_jump(12'd2730);
    wait_drained();

    // Zero grid dimensions, oversized count saturates, longest period
    write_reg(REG_GRID_ROWS, 16'd0);
    write_reg(REG_GRID_COLUMNS, 16'd0);
    write_reg(REG_SPRITE_COUNT, 16'hFFFF);
    write_reg(REG_UPDATE_PERIOD, 16'hFFFF);
    write_reg(REG_SHEET_WIDTH, 16'hFFFF);
    @(negedge clk);
    in_idle  = 1'b1;
    out_idle = 1'b1;
    push_tick('1);
    push_tick('1);
    push_tick(16'd1);
    push_jump('1);
    push_tick('0);
    wait_drained();

    // Oversized grid, tiny count, zero-width sheet; spare indexes must not reset the frame
    write_reg(REG_GRID_ROWS, 16'd127);
    write_reg(REG_GRID_COLUMNS, 16'd127);
    write_reg(REG_SPRITE_COUNT, 16'd5);
    write_reg(REG_UPDATE_PERIOD, 16'd3);
    write_reg(REG_SHEET_WIDTH, 16'd0);
    write_reg(REG_SHEET_HEIGHT, 16'd100);
    @(negedge clk);
    push_jump(12'd4000);
    wait_drained();
    write_reg(REG_SPARE_LO, 16'h1234);
    @(negedge clk);
    push_tick(16'd7);
    wait_drained();
    write_reg(REG_SPARE_HI, 16'hFFFF);
    @(negedge clk);
    push_tick(16'd2);

    // Random phases: reconfigure while idle, then a burst of items
    phase = 0;
    while (items_pushed < ITEM_BUDGET) begin
      wait_drained();
      for (int idx = REG_SHEET_WIDTH; idx <= REG_UPDATE_PERIOD; idx++) begin
        if ($urandom_range(0, 1)) write_reg(CFG_INDEX_W'(idx), random_reg_value(idx));
      end
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                  CFG_DATA_W'($urandom_range(0, 65535)));
      @(negedge clk);
      in_idle  = $urandom_range(0, 1);
      out_idle = $urandom_range(0, 1);
      repeat ($urandom_range(40, 120)) push_random_item();
      // Starve the output once while the driver keeps offering
      if (phase == 3) hold_request = 1'b1;
      phase++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && clip_queue.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ssfs_pkg.sv
sv/ssfs_div.sv
sv/ssfs_mul.sv
sv/sprite_sheet_frame_sequencer_unit.sv
tb/sv/tb_sprite_sheet_frame_sequencer_unit.sv
